/* design/bgns_pkg.sv */
package bgns_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_PASSES = 4;

    localparam int WIDTH_W    = 7;
    localparam int PASSES_W   = 3;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int NB_CNT_W   = 4;

    localparam logic [NB_CNT_W-1:0] WALL_KEEP_MIN  = NB_CNT_W'(4);
    localparam logic [NB_CNT_W-1:0] FLOOR_FILL_MIN = NB_CNT_W'(5);

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_PASSES = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic active;
        logic clear;
        row_t interior;
    } stage_cfg_t;

endpackage

/* design/binary_grid_neighbour_smoothing.sv */
// Binary grid smoothing cascade, 4-5 rule, one grid row per transfer.
// Input channel: row_bits/row_last with in_valid/in_ready. Output channel:
// out_row_bits/out_row_last with out_valid/out_ready. Bit x is column x,
// 1 = wall. Columns at and above width_in_use (0 acts as 1) are zeroed.
// Config: cfg_write/cfg_index/cfg_data, index 0 = width_in_use,
// index 1 = passes_in_use. Any write restarts every pass stage; write only
// while the block is idle.
// Four pass stages in a chain, each with a registered output; a stage beyond
// passes_in_use just forwards rows. Each stage is a row of 64 column lanes.
// Throughput: one row per cycle while no stage stalls. Besides the output
// registers, each active pass adds one row of delay (it waits for the row
// below). The last row of a grid flushes held rows: it gives up to
// passes_in_use+1 output rows; an active stage holding two rows parks the
// last row and stalls its input until it moves to the output register.
// Low out_ready holds the output; a full chain drops in_ready the same cycle.
// Reset: width 64, 4 passes, all stages empty, no output pending.
module binary_grid_neighbour_smoothing (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bgns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgns_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [63:0]                        row_bits,
    input  logic                               row_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [63:0]                        out_row_bits,
    output logic                               out_row_last
);

    localparam int NS = bgns_pkg::MAX_PASSES;
    localparam int EW = bgns_pkg::WIDTH_W + 1;

    logic [bgns_pkg::WIDTH_W-1:0]  width_reg;
    logic [bgns_pkg::PASSES_W-1:0] passes_reg;
    logic [EW-1:0]                 width_eff;
    int unsigned                   passes_eff;
    bgns_pkg::row_t                col_mask;
    bgns_pkg::row_t                col_interior;

    logic                          vld [NS+1];
    logic                          rdy [NS+1];
    bgns_pkg::row_t                rows [NS+1];
    logic                          lst [NS+1];
    bgns_pkg::stage_cfg_t          scfg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bgns_pkg::WIDTH_W'(bgns_pkg::MAX_WIDTH);
            passes_reg <= bgns_pkg::PASSES_W'(bgns_pkg::MAX_PASSES);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bgns_pkg::CFG_WIDTH:  width_reg  <= cfg_data[bgns_pkg::WIDTH_W-1:0];
                bgns_pkg::CFG_PASSES: passes_reg <= cfg_data[bgns_pkg::PASSES_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            width_eff = EW'(1);
        else if (EW'(width_reg) > EW'(bgns_pkg::MAX_WIDTH))
            width_eff = EW'(bgns_pkg::MAX_WIDTH);
        else
            width_eff = EW'(width_reg);

        if (int'(passes_reg) > NS)
            passes_eff = NS;
        else
            passes_eff = int'(passes_reg);

        for (int x = 0; x < bgns_pkg::MAX_WIDTH; x++)
        begin
            col_mask[x]     = EW'(x) < width_eff;
            col_interior[x] = (x >= 1) && (EW'(x + 1) < width_eff);
        end
    end

    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];
    assign rows[0]  = row_bits & col_mask;
    assign lst[0]   = row_last;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        assign scfg[s].active   = s < passes_eff;
        assign scfg[s].clear    = cfg_write;
        assign scfg[s].interior = col_interior;

        bgns_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (scfg[s]),
            .in_valid  (vld[s]),
            .in_ready  (rdy[s]),
            .in_row    (rows[s]),
            .in_last   (lst[s]),
            .out_valid (vld[s+1]),
            .out_ready (rdy[s+1]),
            .out_row   (rows[s+1]),
            .out_last  (lst[s+1])
        );
    end

    assign out_valid    = vld[NS];
    assign rdy[NS]      = out_ready;
    assign out_row_bits = rows[NS];
    assign out_row_last = lst[NS];

endmodule

/* design/bgns_lane.sv */
module bgns_lane (
    input  logic [2:0] win_up,
    input  logic [2:0] win_mid,
    input  logic [2:0] win_dn,
    input  logic       interior,
    output logic       cell_next
);

    logic [bgns_pkg::NB_CNT_W-1:0] walls;
    logic                          rule;

    assign walls = bgns_pkg::NB_CNT_W'(win_up[0]) + bgns_pkg::NB_CNT_W'(win_up[1])
                 + bgns_pkg::NB_CNT_W'(win_up[2]) + bgns_pkg::NB_CNT_W'(win_mid[0])
                 + bgns_pkg::NB_CNT_W'(win_mid[2]) + bgns_pkg::NB_CNT_W'(win_dn[0])
                 + bgns_pkg::NB_CNT_W'(win_dn[1]) + bgns_pkg::NB_CNT_W'(win_dn[2]);

    assign rule = win_mid[1] ? (walls >= bgns_pkg::WALL_KEEP_MIN)
                             : (walls >= bgns_pkg::FLOOR_FILL_MIN);

    assign cell_next = interior ? rule : win_mid[1];

endmodule

/* design/bgns_stage.sv */
module bgns_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bgns_pkg::stage_cfg_t cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bgns_pkg::row_t       in_row,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bgns_pkg::row_t       out_row,
    output logic                 out_last
);

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_TWO
    } phase_t;

    phase_t                       phase_reg, phase_next;
    bgns_pkg::row_t               a_reg, a_next;
    bgns_pkg::row_t               b_reg, b_next;
    logic                         out_valid_reg, out_valid_next;
    bgns_pkg::row_t               out_row_reg, out_row_next;
    logic                         out_last_reg, out_last_next;
    logic                         pend_valid_reg, pend_valid_next;
    bgns_pkg::row_t               pend_row_reg, pend_row_next;
    bgns_pkg::row_t               smooth_row;
    logic [bgns_pkg::MAX_WIDTH+1:0] up_pad, mid_pad, dn_pad;
    logic                         take;

    assign up_pad  = {1'b0, a_reg, 1'b0};
    assign mid_pad = {1'b0, b_reg, 1'b0};
    assign dn_pad  = {1'b0, in_row, 1'b0};

    for (genvar x = 0; x < bgns_pkg::MAX_WIDTH; x++) begin : g_lane
        bgns_lane u_lane (
            .win_up    (up_pad[x+2:x]),
            .win_mid   (mid_pad[x+2:x]),
            .win_dn    (dn_pad[x+2:x]),
            .interior  (cfg.interior[x]),
            .cell_next (smooth_row[x])
        );
    end

    assign in_ready  = !pend_valid_reg && (!out_valid_reg || out_ready);
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_row_next    = out_row_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next  = pend_valid_reg;
            out_row_next    = pend_row_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (take)
        begin
            if (!cfg.active)
            begin
                out_valid_next = 1'b1;
                out_row_next   = in_row;
                out_last_next  = in_last;
            end
            else
            begin
                case (phase_reg)
                    PH_EMPTY:
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = in_row;
                        out_last_next  = in_last;
                        a_next         = in_row;
                        phase_next     = in_last ? PH_EMPTY : PH_ONE;
                    end
                    PH_ONE:
                    begin
                        if (in_last)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = in_row;
                            out_last_next  = 1'b1;
                            phase_next     = PH_EMPTY;
                        end
                        else
                        begin
                            b_next     = in_row;
                            phase_next = PH_TWO;
                        end
                    end
                    PH_TWO:
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = smooth_row;
                        out_last_next  = 1'b0;
                        if (in_last)
                        begin
                            pend_valid_next = 1'b1;
                            pend_row_next   = in_row;
                            phase_next      = PH_EMPTY;
                        end
                        else
                        begin
                            a_next = b_reg;
                            b_next = in_row;
                        end
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = in_row;
                        out_last_next  = in_last;
                        phase_next     = PH_EMPTY;
                    end
                endcase
            end
        end

        if (cfg.clear)
        begin
            phase_next = PH_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_EMPTY;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
        pend_row_reg <= pend_row_next;
    end

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("flush row held without a row in the output register");

    a_pend_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_valid_reg) |-> $past(take && in_last && cfg.active && phase_reg == PH_TWO))
        else $error("flush row loaded outside a last-row transfer in full window");

    a_bypass_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg.active && !cfg.clear) |=> phase_reg == $past(phase_reg))
        else $error("phase moved in a bypassed stage");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> phase_reg == PH_EMPTY)
        else $error("config write did not drop the held window");

endmodule

/* dv/binary_grid_neighbour_smoothing_checker.sv */
`timescale 1ns / 1ps

module binary_grid_neighbour_smoothing_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bgns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgns_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [63:0]                     row_bits,
    input  logic                            row_last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [63:0]                     out_row_bits,
    input  logic                            out_row_last,
    output int unsigned                     pending_rows,
    output int unsigned                     failures
);

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef struct packed {
        bgns_pkg::row_t bits;
        logic           last;
    } grid_row_t;

    grid_row_t                     expected_rows[$];
    bgns_pkg::row_t                older_row[bgns_pkg::MAX_PASSES];
    bgns_pkg::row_t                newer_row[bgns_pkg::MAX_PASSES];
    logic [1:0]                    rows_held[bgns_pkg::MAX_PASSES];
    logic [bgns_pkg::WIDTH_W-1:0]  width_reg;
    logic [bgns_pkg::PASSES_W-1:0] passes_reg;

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > bgns_pkg::MAX_WIDTH)
            w = bgns_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic bgns_pkg::row_t smooth_row(bgns_pkg::row_t up, bgns_pkg::row_t mid,
                                                  bgns_pkg::row_t dn, int w);
        bgns_pkg::row_t res;
        int             walls;
        int             x;
        res = mid;
        for (x = 1; x + 1 < w; x++)
        begin
            walls = int'(up[x-1]) + int'(up[x]) + int'(up[x+1])
                  + int'(mid[x-1]) + int'(mid[x+1])
                  + int'(dn[x-1]) + int'(dn[x]) + int'(dn[x+1]);
            if (mid[x])
                res[x] = (walls >= int'(bgns_pkg::WALL_KEEP_MIN));
            else
                res[x] = (walls >= int'(bgns_pkg::FLOOR_FILL_MIN));
        end
        return res;
    endfunction

    // Runs one input row through the active pass stages and queues what leaves.
    task automatic smooth_into_expected(bgns_pkg::row_t bits, logic last);
        grid_row_t      stream[$];
        grid_row_t      passed[$];
        grid_row_t      item;
        bgns_pkg::row_t mask;
        int             w;
        int             npasses;
        int             s;
        w = active_width();
        mask = (w >= 64) ? '1 : ((bgns_pkg::row_t'(1) << w) - bgns_pkg::row_t'(1));
        npasses = (int'(passes_reg) > bgns_pkg::MAX_PASSES) ? bgns_pkg::MAX_PASSES
                                                             : int'(passes_reg);
        stream.push_back(grid_row_t'{bits: bits & mask, last: last});
        for (s = 0; s < npasses; s++)
        begin
            passed.delete();
            foreach (stream[i])
            begin
                item = stream[i];
                case (rows_held[s])
                    HELD_NONE:
                    begin
                        passed.push_back(item);
                        older_row[s] = item.bits;
                        rows_held[s] = item.last ? HELD_NONE : HELD_ONE;
                    end
                    HELD_ONE:
                    begin
                        if (item.last)
                        begin
                            passed.push_back(item);
                            rows_held[s] = HELD_NONE;
                        end
                        else
                        begin
                            newer_row[s] = item.bits;
                            rows_held[s] = HELD_TWO;
                        end
                    end
                    default:
                    begin
                        passed.push_back(grid_row_t'{
                            bits: smooth_row(older_row[s], newer_row[s], item.bits, w),
                            last: 1'b0});
                        if (item.last)
                        begin
                            passed.push_back(item);
                            rows_held[s] = HELD_NONE;
                        end
                        else
                        begin
                            older_row[s] = newer_row[s];
                            newer_row[s] = item.bits;
                        end
                    end
                endcase
            end
            stream = passed;
        end
        foreach (stream[i])
            expected_rows.push_back(grid_row_t'{bits: stream[i].bits & mask,
                                                last: stream[i].last});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_row_t want;
        if (!rst_n)
        begin
            expected_rows.delete();
            width_reg  = bgns_pkg::WIDTH_W'(bgns_pkg::MAX_WIDTH);
            passes_reg = bgns_pkg::PASSES_W'(bgns_pkg::MAX_PASSES);
            failures   = 0;
            for (int s = 0; s < bgns_pkg::MAX_PASSES; s++)
            begin
                older_row[s] = '0;
                newer_row[s] = '0;
                rows_held[s] = HELD_NONE;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (bgns_pkg::cfg_reg_t'(cfg_index))
                    bgns_pkg::CFG_WIDTH:  width_reg  = cfg_data[bgns_pkg::WIDTH_W-1:0];
                    bgns_pkg::CFG_PASSES: passes_reg = cfg_data[bgns_pkg::PASSES_W-1:0];
                    default:              ;
                endcase
                for (int s = 0; s < bgns_pkg::MAX_PASSES; s++)
                    rows_held[s] = HELD_NONE;
            end
            if (in_valid && in_ready)
                smooth_into_expected(row_bits, row_last);
            if (out_valid && out_ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, actual bits %h last %b",
                             $time, out_row_bits, out_row_last);
                    failures++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (want.bits !== out_row_bits)
                    begin
                        $display("%0t: out_row_bits expected %h, actual %h",
                                 $time, want.bits, out_row_bits);
                        failures++;
                    end
                    if (want.last !== out_row_last)
                    begin
                        $display("%0t: out_row_last expected %b, actual %b",
                                 $time, want.last, out_row_last);
                        failures++;
                    end
                end
            end
        end
        pending_rows = expected_rows.size();
    end

endmodule

/* dv/binary_grid_neighbour_smoothing_test.sv */
`timescale 1ns / 1ps

module binary_grid_neighbour_smoothing_test;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH,
        IDLE_PRESSURE
    } idle_mode_t;

    localparam int SETTLE_CYCLES   = 24;
    localparam int PRESSURE_CYCLES = 90;
    localparam int ROWS_PER_MODE   = 64;
    localparam int DW              = bgns_pkg::CFG_DATA_W;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [bgns_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DW-1:0]                   cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [63:0]                     row_bits  = '0;
    logic                            row_last  = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [63:0]                     out_row_bits;
    logic                            out_row_last;
    int unsigned                     pending_rows;
    int unsigned                     failures;

    idle_mode_t idle_mode     = IDLE_NONE;
    bit         pressure_done = 1'b0;

    binary_grid_neighbour_smoothing i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_bits     (row_bits),
        .row_last     (row_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row_bits (out_row_bits),
        .out_row_last (out_row_last)
    );

    binary_grid_neighbour_smoothing_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_bits     (row_bits),
        .row_last     (row_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row_bits (out_row_bits),
        .out_row_last (out_row_last),
        .pending_rows (pending_rows),
        .failures     (failures)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("binary_grid_neighbour_smoothing_test failed");
        $finish;
    end

    // sparse, plain or dense rows to land on both sides of the wall thresholds
    function automatic bgns_pkg::row_t random_row();
        bgns_pkg::row_t a;
        bgns_pkg::row_t b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(2))
            0:       return a;
            1:       return a & b;
            default: return a | b;
        endcase
    endfunction

    function automatic logic [DW-1:0] random_width();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return DW'($urandom_range(2));
        else if (pick < 20)
            return DW'($urandom_range(127, 65));
        else if (pick < 30)
            return DW'(64);
        else
            return DW'($urandom_range(64, 3));
    endfunction

    task automatic send_row(bgns_pkg::row_t bits, logic last);
        int gap_pct;
        case (idle_mode)
            IDLE_SENDER: gap_pct = 48;
            IDLE_BOTH:   gap_pct = 28;
            default:     gap_pct = 0;
        endcase
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        row_bits <= bits;
        row_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drains the block; rows held by an open grid never show up here
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rows != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(bgns_pkg::cfg_reg_t idx, logic [DW-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int stall_pct;
        forever
        begin
            @(posedge clk);
            if (idle_mode == IDLE_PRESSURE && !pressure_done)
            begin
                pressure_done = 1'b1;
                out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            case (idle_mode)
                IDLE_RECEIVER: stall_pct = 48;
                IDLE_BOTH:     stall_pct = 28;
                default:       stall_pct = 0;
            endcase
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        idle_mode_t modes[5];
        int         sent;
        int         height;
        bit         open_grid;
        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_PRESSURE};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 64 columns, 4 passes
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row({32{2'b10}}, 1'b0);
        send_row({32{2'b01}}, 1'b0);
        send_row('1, 1'b1);
        send_row('1, 1'b1);
        send_row(random_row(), 1'b0);
        send_row('0, 1'b1);
        // grid left open, then dropped by the next write
        repeat (3) send_row(random_row(), 1'b0);
        wait_quiet();
        write_cfg(bgns_pkg::CFG_WIDTH, '0);
        repeat (2) send_row(random_row(), 1'b0);
        send_row(random_row(), 1'b1);
        wait_quiet();
        write_cfg(bgns_pkg::CFG_WIDTH, DW'(2));
        write_cfg(bgns_pkg::CFG_PASSES, DW'(7));
        repeat (2) send_row(random_row(), 1'b0);
        send_row('1, 1'b1);
        wait_quiet();
        write_cfg(bgns_pkg::CFG_WIDTH, '1);
        write_cfg(bgns_pkg::CFG_PASSES, '0);
        repeat (2) send_row(random_row(), 1'b0);
        send_row('1, 1'b1);
        wait_quiet();
        write_cfg(bgns_pkg::CFG_WIDTH, DW'(3));
        write_cfg(bgns_pkg::CFG_PASSES, DW'(1));
        send_row('1, 1'b0);
        send_row({32{2'b10}}, 1'b0);
        send_row('1, 1'b0);
        send_row('0, 1'b1);
        wait_quiet();
        write_cfg(bgns_pkg::CFG_WIDTH, DW'(64));
        write_cfg(bgns_pkg::CFG_PASSES, DW'(4));

        foreach (modes[m])
        begin
            idle_mode <= modes[m];
            sent = 0;
            while (sent < ROWS_PER_MODE)
            begin
                if (sent > 0 && $urandom_range(99) < 35)
                begin
                    wait_quiet();
                    write_cfg(bgns_pkg::CFG_WIDTH, random_width());
                    if ($urandom_range(1))
                        write_cfg(bgns_pkg::CFG_PASSES, DW'($urandom_range(7)));
                end
                height = ($urandom_range(99) < 15) ? $urandom_range(2, 1)
                                                   : $urandom_range(10, 3);
                open_grid = ($urandom_range(99) < 6);
                for (int r = 0; r < height; r++)
                    send_row(random_row(), !open_grid && r == height - 1);
                if (open_grid)
                begin
                    wait_quiet();
                    write_cfg(bgns_pkg::CFG_PASSES, DW'($urandom_range(7)));
                end
                sent += height;
            end
        end

        wait_quiet();
        if (failures == 0)
            $display("binary_grid_neighbour_smoothing_test passed");
        else
            $display("binary_grid_neighbour_smoothing_test failed");
        $finish;
    end

endmodule
